[sv/epsilon_greedy_arm_selector_defines.svh]
// ---------------------------------------------------------------------------
// Epsilon-greedy arm selector: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef EPSILON_GREEDY_ARM_SELECTOR_DEFINES_SVH
`define EPSILON_GREEDY_ARM_SELECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EGAS_ASSERT_IMP(lbl, clk_s, rstn_s, ant, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define EGAS_ASSERT_NXT(lbl, clk_s, rstn_s, ant, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |=> (cons)) \
		else $error(msg);
`else
`define EGAS_ASSERT_IMP(lbl, clk_s, rstn_s, ant, cons, msg)
`define EGAS_ASSERT_NXT(lbl, clk_s, rstn_s, ant, cons, msg)
`endif
`endif

[sv/egas_pkg.sv]
// ---------------------------------------------------------------------------
// egas_pkg
// Shared types and constants of the epsilon-greedy arm selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package egas_pkg;

	// defaults for the top-level parameters
	localparam int ARMS_DEF      = 64;
	localparam int FRAC_BITS_DEF = 8;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_PICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// configuration register indexes
	localparam logic REG_ARMS_IN_USE = 1'b0;
	localparam logic REG_EXPLORE     = 1'b1;

	localparam int CFG_W = 17;
	localparam logic [6:0] ARMS_IN_USE_RST = 7'd10;

	// input word
	typedef struct packed {
		logic [1:0]  command;
		logic [5:0]  arm_index;
		logic [7:0]  reward_value;
		logic [15:0] random_draw;
	} item_t;

	// output word
	typedef struct packed {
		logic        status;
		logic [5:0]  chosen_arm;
		logic        explored;
		logic [7:0]  reward_earned;
		logic [15:0] new_estimate;
		logic [23:0] arm_earnings;
		logic [6:0]  first_pick_rank;
		logic [31:0] total_earning;
	} result_t;

	// learning state of one arm
	typedef struct packed {
		logic [15:0] count;
		logic [15:0] estimate;
		logic [23:0] earnings;
		logic [6:0]  rank;
	} arm_row_t;

	// store write controls
	typedef struct packed {
		logic row_we;
		logic rew_we;
		logic clear;
	} mem_ctl_t;

endpackage

`default_nettype wire

[sv/egas_divider.sv]
// ---------------------------------------------------------------------------
// egas_divider
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egas_divider #(
	parameter int NB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NB-1:0] dividend,
	input  wire logic [15:0]   divisor,
	output logic               done,
	output logic [NB-1:0]      quotient
);

	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] num_q;
	logic [15:0]   rem_q;
	logic [15:0]   div_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [16:0]   trial;
	logic          ge;
	logic [16:0]   diff;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, num_q[NB-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// operands; quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			num_q <= {num_q[NB-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

[sv/egas_arm_store.sv]
// ---------------------------------------------------------------------------
// egas_arm_store
// Per-arm reward table and learning rows, registered read, valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egas_arm_store #(
	parameter int ARMS      = egas_pkg::ARMS_DEF,
	parameter int FRAC_BITS = egas_pkg::FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire egas_pkg::mem_ctl_t       ctl,
	input  wire logic [$clog2(ARMS)-1:0]  wr_addr,
	input  wire egas_pkg::arm_row_t       row_wdata,
	input  wire logic [7:0]               rew_wdata,
	input  wire logic [$clog2(ARMS)-1:0]  rd_addr,
	output egas_pkg::arm_row_t            row_rdata,
	output logic [7:0]                    rew_rdata
);

	localparam logic [15:0] EST_HALF = 16'(1 << (FRAC_BITS - 1));

	egas_pkg::arm_row_t row_mem [ARMS];
	logic [7:0]         rew_mem [ARMS];
	logic [ARMS-1:0]    row_vld_q;
	logic [ARMS-1:0]    rew_vld_q;
	egas_pkg::arm_row_t row_rd_q;
	logic [7:0]         rew_rd_q;
	logic               row_hit_q;
	logic               rew_hit_q;
	egas_pkg::arm_row_t row_rst;

	// memories: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.row_we) begin
			row_mem[wr_addr] <= row_wdata;
		end
		if (ctl.rew_we) begin
			rew_mem[wr_addr] <= rew_wdata;
		end
		row_rd_q <= row_mem[rd_addr];
		rew_rd_q <= rew_mem[rd_addr];
	end

	// valid bits; clear drops only the learning rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rew_vld_q <= '0;
			row_hit_q <= 1'b0;
			rew_hit_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				row_vld_q <= '0;
			end else if (ctl.row_we) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rew_we) begin
				rew_vld_q[wr_addr] <= 1'b1;
			end
			row_hit_q <= row_vld_q[rd_addr];
			rew_hit_q <= rew_vld_q[rd_addr];
		end
	end

	// unwritten entries read as their reset value
	always_comb begin
		row_rst          = '0;
		row_rst.estimate = EST_HALF;
		row_rdata        = row_hit_q ? row_rd_q : row_rst;
		rew_rdata        = rew_hit_q ? rew_rd_q : 8'd0;
	end

endmodule

`default_nettype wire

[sv/epsilon_greedy_arm_selector.sv]
// ---------------------------------------------------------------------------
// epsilon_greedy_arm_selector
// Epsilon-greedy bandit: reward table, estimates, argmax walk, divider.
// ---------------------------------------------------------------------------
// Usage: configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle. Command words arrive on item/item_valid and are taken
// when item_stall is low; every word yields exactly one result word on
// result/result_valid, held until result_stall is low.
// item_stall stays high from acceptance until the result has been moved
// into the output register, so one word is in work at a time; a new word
// can be taken while the previous result still waits for the receiver.
// A load reads the arm and reports its state; an exploring pick fetches
// the given arm, updates it and divides; a greedy pick first walks the
// estimates of all arms in use. Clear, unused commands and ignored items
// go straight to the output. The greedy walk reads one estimate per cycle
// from the learning memory; the divider delivers one quotient bit per cycle.
// Reset empties the reward table and all learning state at once (valid
// bits), and sets arms_in_use to 10 and explore_threshold to 0.
// A stalled receiver holds the result and, in turn, the next item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "epsilon_greedy_arm_selector_defines.svh"

module epsilon_greedy_arm_selector #(
	parameter int ARMS      = egas_pkg::ARMS_DEF,
	parameter int FRAC_BITS = egas_pkg::FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [egas_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire egas_pkg::item_t            item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output egas_pkg::result_t               result
);

	localparam int AW = $clog2(ARMS);
	localparam int NW = $clog2(ARMS + 1);
	localparam int NB = 8 + FRAC_BITS;

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_LOAD_RD   = 4'd1;
	localparam logic [3:0] ST_LOAD_RPT  = 4'd2;
	localparam logic [3:0] ST_SCAN      = 4'd3;
	localparam logic [3:0] ST_SCAN_LAST = 4'd4;
	localparam logic [3:0] ST_FETCH     = 4'd5;
	localparam logic [3:0] ST_UPDATE    = 4'd6;
	localparam logic [3:0] ST_DIVIDE    = 4'd7;
	localparam logic [3:0] ST_EMIT      = 4'd8;

	logic [3:0]         state_q;
	logic [6:0]         arms_in_use_q;
	logic [16:0]        explore_q;
	logic [NW-1:0]      nact;
	logic               accept;
	logic               idx_bad;
	logic               explore;
	logic               ignore;
	logic [AW-1:0]      arm_q;
	logic               expl_q;
	logic [AW-1:0]      scan_q;
	logic               scan_last;
	logic               cmp_vld_s1;
	logic [AW-1:0]      cmp_idx_s1;
	logic [15:0]        best_est_q;
	logic [AW-1:0]      best_arm_q;
	logic               take;
	logic [6:0]         distinct_q;
	logic [31:0]        total_q;
	logic [7:0]         r_q;
	logic [15:0]        cnt_q;
	logic [23:0]        earn_q;
	logic [6:0]         rank_q;
	logic [15:0]        cnt_nx;
	logic [24:0]        earn_sum;
	logic [23:0]        earn_nx;
	logic [32:0]        total_sum;
	logic [31:0]        total_nx;
	logic [6:0]         distinct_nx;
	logic [6:0]         rank_nx;
	logic [31:0]        quot_w;
	logic [15:0]        est_nx;
	logic               slot_free;
	egas_pkg::result_t  res_q;
	egas_pkg::result_t  res_bad;
	egas_pkg::result_t  res_load;
	egas_pkg::result_t  result_q;
	logic               result_valid_q;
	egas_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	egas_pkg::arm_row_t row_wdata;
	egas_pkg::arm_row_t row_rdata;
	logic [7:0]         rew_rdata;
	logic               div_start;
	logic               div_done;
	logic [NB-1:0]      div_quot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arms_in_use_q <= egas_pkg::ARMS_IN_USE_RST;
			explore_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				egas_pkg::REG_ARMS_IN_USE: arms_in_use_q <= cfg_data[6:0];
				egas_pkg::REG_EXPLORE:     explore_q     <= cfg_data;
				default:                   ;
			endcase
		end
	end

	// item decode
	always_comb begin
		nact    = (32'(arms_in_use_q) > ARMS) ? NW'(ARMS) : NW'(arms_in_use_q);
		accept  = item_valid && !item_stall;
		idx_bad = 32'(item.arm_index) >= 32'(nact);
		explore = {1'b0, item.random_draw} < explore_q;
		ignore  = (item.command == egas_pkg::CMD_LOAD ||
			item.command == egas_pkg::CMD_PICK) && (idx_bad || nact == '0);
		res_bad = '0;
		res_bad.status     = 1'b1;
		res_bad.chosen_arm = item.arm_index;
	end

	// argmax walk: last arm holding the largest estimate wins
	always_comb begin
		scan_last = (32'(scan_q) + 32'd1) == 32'(nact);
		take      = cmp_vld_s1 &&
			((cmp_idx_s1 == '0) || (row_rdata.estimate >= best_est_q));
	end

	// update arithmetic for the chosen arm
	always_comb begin
		cnt_nx      = (row_rdata.count == 16'hFFFF) ? 16'hFFFF : row_rdata.count + 16'd1;
		earn_sum    = {1'b0, row_rdata.earnings} + 25'(rew_rdata);
		earn_nx     = earn_sum[24] ? 24'hFFFFFF : earn_sum[23:0];
		total_sum   = {1'b0, total_q} + 33'(rew_rdata);
		total_nx    = total_sum[32] ? 32'hFFFFFFFF : total_sum[31:0];
		distinct_nx = distinct_q;
		rank_nx     = row_rdata.rank;
		if (row_rdata.rank == '0) begin
			distinct_nx = (distinct_q == 7'd127) ? 7'd127 : distinct_q + 7'd1;
			rank_nx     = distinct_nx;
		end
		quot_w = 32'(div_quot);
		est_nx = (quot_w > 32'hFFFF) ? 16'hFFFF : quot_w[15:0];
	end

	// load report: current state of the loaded arm
	always_comb begin
		res_load                 = '0;
		res_load.chosen_arm      = 6'(arm_q);
		res_load.new_estimate    = row_rdata.estimate;
		res_load.arm_earnings    = row_rdata.earnings;
		res_load.first_pick_rank = row_rdata.rank;
		res_load.total_earning   = total_q;
	end

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmp_vld_s1 <= 1'b0;
			distinct_q <= '0;
			total_q    <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.command)
							egas_pkg::CMD_LOAD: begin
								if (idx_bad) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_LOAD_RD;
								end
							end
							egas_pkg::CMD_PICK: begin
								if (nact == '0 || (explore && idx_bad)) begin
									state_q <= ST_EMIT;
								end else if (explore) begin
									state_q <= ST_FETCH;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							egas_pkg::CMD_CLEAR: begin
								distinct_q <= '0;
								total_q    <= '0;
								state_q    <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_LOAD_RD:   state_q <= ST_LOAD_RPT;
				ST_LOAD_RPT:  state_q <= ST_EMIT;
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_SCAN_LAST;
					end
				end
				ST_SCAN_LAST: state_q <= ST_FETCH;
				ST_FETCH:     state_q <= ST_UPDATE;
				ST_UPDATE: begin
					distinct_q <= distinct_nx;
					total_q    <= total_nx;
					state_q    <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (take) begin
			best_est_q <= row_rdata.estimate;
			best_arm_q <= cmp_idx_s1;
		end
		case (state_q)
			ST_IDLE: begin
				arm_q  <= AW'(item.arm_index);
				expl_q <= explore;
				scan_q <= '0;
				res_q  <= ignore ? res_bad : '0;
			end
			ST_LOAD_RPT:  res_q <= res_load;
			ST_SCAN:      scan_q <= scan_q + AW'(1);
			ST_SCAN_LAST: arm_q <= take ? cmp_idx_s1 : best_arm_q;
			ST_UPDATE: begin
				r_q    <= rew_rdata;
				cnt_q  <= cnt_nx;
				earn_q <= earn_nx;
				rank_q <= rank_nx;
			end
			ST_DIVIDE: begin
				res_q.status          <= 1'b0;
				res_q.chosen_arm      <= 6'(arm_q);
				res_q.explored        <= expl_q;
				res_q.reward_earned   <= r_q;
				res_q.new_estimate    <= est_nx;
				res_q.arm_earnings    <= earn_q;
				res_q.first_pick_rank <= rank_q;
				res_q.total_earning   <= total_q;
			end
			default: ;
		endcase
	end

	// output register
	assign slot_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			result_q <= res_q;
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// store access
	always_comb begin
		mem_ctl.rew_we = accept && item.command == egas_pkg::CMD_LOAD && !idx_bad;
		mem_ctl.clear  = accept && item.command == egas_pkg::CMD_CLEAR;
		mem_ctl.row_we = state_q == ST_DIVIDE && div_done;
		wr_addr        = (state_q == ST_IDLE) ? AW'(item.arm_index) : arm_q;
		rd_addr        = (state_q == ST_SCAN) ? scan_q : arm_q;
		row_wdata.count    = cnt_q;
		row_wdata.estimate = est_nx;
		row_wdata.earnings = earn_q;
		row_wdata.rank     = rank_q;
		div_start          = state_q == ST_UPDATE;
	end

	egas_arm_store #(
		.ARMS      (ARMS),
		.FRAC_BITS (FRAC_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mem_ctl),
		.wr_addr   (wr_addr),
		.row_wdata (row_wdata),
		.rew_wdata (item.reward_value),
		.rd_addr   (rd_addr),
		.row_rdata (row_rdata),
		.rew_rdata (rew_rdata)
	);

	// estimate = (reward << FRAC_BITS) / count
	egas_divider #(
		.NB (NB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (NB'(rew_rdata) << FRAC_BITS),
		.divisor  (cnt_nx),
		.done     (div_done),
		.quotient (div_quot)
	);

	// checks
	`EGAS_ASSERT_IMP(a_div_done_in_divide, clk, arst_n, div_done, state_q == ST_DIVIDE, "divider finished outside the divide step")
	`EGAS_ASSERT_IMP(a_last_compare_live, clk, arst_n, state_q == ST_SCAN_LAST, cmp_vld_s1, "final estimate compare missing")
	`EGAS_ASSERT_IMP(a_fetch_arm_in_range, clk, arst_n, state_q == ST_FETCH, 32'(arm_q) < 32'(nact), "chosen arm not among arms in use")
	`EGAS_ASSERT_NXT(a_emit_waits, clk, arst_n, state_q == ST_EMIT && result_valid && result_stall, state_q == ST_EMIT && result_valid, "result dropped while receiver stalls")

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: epsilon-greedy arm selector testbench
// Drives load, pick, clear and unused command words through the
// valid/stall port and mirrors the bandit's reward table and learning state
// in a scoreboard. Each accepted word is checked field by field against the
// predicted result. Runs a directed part, then random phases over several
// arm counts and exploration thresholds. Both ports idle at random except
// in the final phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import egas_pkg::*;

	localparam int NUM_ARMS = ARMS_DEF;
	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 9;

	// Mirror of the bandit state; predicts one result per accepted word
	class bandit_scoreboard;
		bit [7:0]  reward_tbl[NUM_ARMS];
		bit [15:0] picks[NUM_ARMS];
		bit [15:0] estimate[NUM_ARMS];
		bit [23:0] earned[NUM_ARMS];
		bit [6:0]  rank[NUM_ARMS];
		bit [6:0]  ranks_given;
		bit [31:0] grand_total;
		bit [6:0]  arms_reg;
		bit [16:0] thr_reg;
		result_t   outcome_q[$];
		int        errors;

		function void clear_learning();
			for (int k = 0; k < NUM_ARMS; k++) begin
				picks[k] = '0;
				estimate[k] = 16'(1 << (FRAC - 1));
				earned[k] = '0;
				rank[k] = '0;
			end
			ranks_given = '0;
			grand_total = '0;
		endfunction

		function void power_on();
			foreach (reward_tbl[k]) reward_tbl[k] = '0;
			clear_learning();
			arms_reg = ARMS_IN_USE_RST;
			thr_reg = '0;
			errors = 0;
		endfunction

		function void set_register(logic idx, bit [16:0] val);
			if (idx == REG_ARMS_IN_USE)
				arms_reg = val[6:0];
			else
				thr_reg = val;
		endfunction

		function result_t arm_report(int unsigned arm, bit expl, bit [7:0] got);
			result_t r;
			r = '0;
			r.chosen_arm = 6'(arm);
			r.explored = expl;
			r.reward_earned = got;
			r.new_estimate = estimate[arm];
			r.arm_earnings = earned[arm];
			r.first_pick_rank = rank[arm];
			r.total_earning = grand_total;
			return r;
		endfunction

		// predict the result of one accepted word and queue it
		function void note_word(item_t w);
			result_t r;
			int unsigned n, arm, q;
			longint unsigned sum;
			bit take, expl;
			r = '0;
			n = (arms_reg > NUM_ARMS) ? NUM_ARMS : arms_reg;
			case (w.command)
				CMD_CLEAR: clear_learning();
				CMD_LOAD: begin
					if (w.arm_index >= n) begin
						r.status = 1'b1;
						r.chosen_arm = w.arm_index;
					end else begin
						reward_tbl[w.arm_index] = w.reward_value;
						r = arm_report(w.arm_index, 1'b0, 8'd0);
					end
				end
				CMD_PICK: begin
					take = 1'b1;
					expl = 1'b0;
					arm = 0;
					if (n == 0) begin
						take = 1'b0;
					end else if ({1'b0, w.random_draw} < thr_reg) begin
						if (w.arm_index >= n)
							take = 1'b0;
						else begin
							arm = w.arm_index;
							expl = 1'b1;
						end
					end else begin
						// last arm holding the largest estimate
						for (int unsigned k = 1; k < n; k++)
							if (estimate[k] >= estimate[arm]) arm = k;
					end
					if (!take) begin
						r.status = 1'b1;
						r.chosen_arm = w.arm_index;
					end else begin
						if (picks[arm] != 16'hFFFF) picks[arm]++;
						sum = earned[arm] + reward_tbl[arm];
						earned[arm] = (sum > 24'hFFFFFF) ? 24'hFFFFFF : 24'(sum);
						sum = grand_total + reward_tbl[arm];
						grand_total = (sum > 32'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(sum);
						q = (int'(reward_tbl[arm]) << FRAC) / picks[arm];
						estimate[arm] = (q > 16'hFFFF) ? 16'hFFFF : 16'(q);
						if (rank[arm] == 0) begin
							if (ranks_given < 7'd127) ranks_given++;
							rank[arm] = ranks_given;
						end
						r = arm_report(arm, expl, reward_tbl[arm]);
					end
				end
				default: ;
			endcase
			outcome_q.push_back(r);
		endfunction

		function void compare_field(string f, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch: expected %0d actual %0d", $time, f, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result word: expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = outcome_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("chosen_arm", want.chosen_arm, got.chosen_arm);
			compare_field("explored", want.explored, got.explored);
			compare_field("reward_earned", want.reward_earned, got.reward_earned);
			compare_field("new_estimate", want.new_estimate, got.new_estimate);
			compare_field("arm_earnings", want.arm_earnings, got.arm_earnings);
			compare_field("first_pick_rank", want.first_pick_rank, got.first_pick_rank);
			compare_field("total_earning", want.total_earning, got.total_earning);
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;

	bandit_scoreboard sb;
	bit quiet_tail = 1'b0;
	int idle_cycles = 0;

	epsilon_greedy_arm_selector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Monitor both ports and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_word(item);
			if (result_valid && !result_stall)
				sb.check_word(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver back-pressure in short bursts
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else
				result_stall <= 1'b0;
		end
	end

	task automatic send_word(item_t w);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic issue(logic [1:0] cmd, int unsigned arm, int unsigned rv, int unsigned draw);
		item_t w;
		w.command = cmd;
		w.arm_index = 6'(arm);
		w.reward_value = 8'(rv);
		w.random_draw = 16'(draw);
		send_word(w);
	endtask

	// hold the sender until every outstanding word has come back
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_config(int unsigned arms, int unsigned thr);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_ARMS_IN_USE;
		cfg_data <= CFG_W'(arms);
		@(posedge clk);
		sb.set_register(REG_ARMS_IN_USE, 17'(arms));
		cfg_index <= REG_EXPLORE;
		cfg_data <= CFG_W'(thr);
		@(posedge clk);
		sb.set_register(REG_EXPLORE, 17'(thr));
		cfg_we <= 1'b0;
	endtask

	// random word, mostly loads and picks on arms in use
	function automatic item_t random_word(int unsigned n, int unsigned thr);
		item_t w;
		int unsigned sel;
		w.command = CMD_PICK;
		w.arm_index = 6'($urandom_range(0, 63));
		w.reward_value = 8'($urandom_range(0, 255));
		w.random_draw = 16'($urandom_range(0, 65535));
		if (n > 0 && $urandom_range(0, 9) != 0)
			w.arm_index = 6'($urandom_range(0, n - 1));
		if ($urandom_range(0, 7) == 0)
			w.random_draw = (thr == 0) ? 16'd0 :
				(thr > 65535) ? 16'hFFFF : 16'(thr - $urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 22)
			w.command = CMD_LOAD;
		else if (sel < 96)
			w.command = CMD_PICK;
		else if (sel < 98)
			w.command = CMD_CLEAR;
		else
			w.command = CMD_NONE;
		return w;
	endfunction

	int unsigned phase_arms[PHASES] = '{64, 1, 33, 127, 0, 100, 5, 64, 64};
	int unsigned phase_thr[PHASES]  = '{16384, 65536, 32768, 8000, 30000, 1, 49152, 0, 20000};

	initial begin
		int unsigned n_eff, count;
		sb = new;
		sb.power_on();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset defaults, ten arms, purely greedy
		issue(CMD_PICK, 0, 0, 0);
		issue(CMD_LOAD, 0, 255, 0);
		issue(CMD_LOAD, 9, 0, 65535);
		issue(CMD_LOAD, 10, 1, 0);
		issue(CMD_LOAD, 63, 255, 0);
		issue(CMD_LOAD, 3, 128, 0);
		issue(CMD_PICK, 0, 0, 65535);
		issue(CMD_PICK, 0, 0, 0);
		issue(CMD_NONE, 63, 255, 65535);
		issue(CMD_CLEAR, 63, 255, 65535);
		issue(CMD_PICK, 0, 0, 0);
		// always explore over all arms
		write_config(64, 65536);
		issue(CMD_PICK, 63, 0, 65535);
		issue(CMD_PICK, 0, 0, 0);
		issue(CMD_LOAD, 63, 255, 0);
		issue(CMD_PICK, 63, 0, 12345);
		// no arms in use: everything ignored
		write_config(0, 0);
		issue(CMD_LOAD, 0, 7, 0);
		issue(CMD_PICK, 0, 0, 0);
		// arm count above the table size, threshold edge
		write_config(127, 65535);
		issue(CMD_PICK, 63, 0, 65534);
		issue(CMD_PICK, 63, 0, 65535);
		// single arm
		write_config(1, 1);
		issue(CMD_PICK, 1, 0, 0);
		issue(CMD_PICK, 0, 0, 0);
		issue(CMD_PICK, 0, 0, 1);
		issue(CMD_CLEAR, 0, 0, 0);

		// Random phases over several settings; the last one without idling
		for (int p = 0; p < PHASES; p++) begin
			write_config(phase_arms[p], phase_thr[p]);
			n_eff = (phase_arms[p] > NUM_ARMS) ? NUM_ARMS : phase_arms[p];
			count = (phase_arms[p] == 0) ? 40 : 220;
			if (p == PHASES - 1) quiet_tail = 1'b1;
			for (int i = 0; i < count; i++) begin
				if (!quiet_tail && $urandom_range(0, 149) == 0) drain();
				send_word(random_word(n_eff, phase_thr[p]));
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
